FILE: hdl/fpr_pkg.sv
package fpr_pkg;

  localparam int FRAME_DEPTH_DEF = 16;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_FIRST  = 2'd0;
  localparam logic [1:0] CFG_START_SECOND = 2'd1;
  localparam logic [1:0] CFG_CRC_ENABLE   = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CRC,
    SEQ_READ,
    SEQ_OUT
  } seq_t;

  typedef struct packed {
    logic clear;
    logic start;
  } crc_ctrl_t;

endpackage

FILE: hdl/fpr_crc_unit.sv
module fpr_crc_unit (
  input  logic              clk,
  input  logic              rst,
  input  fpr_pkg::crc_ctrl_t ctrl,
  input  logic [7:0]        data_in,
  output logic [15:0]       crc,
  output logic              busy,
  output logic              done
);
  import fpr_pkg::*;

  localparam logic [2:0] CntLast = 3'd7;

  logic [15:0] crc_reg;
  logic [7:0]  shift;
  logic [2:0]  cnt;
  logic        busy_reg;
  logic [15:0] crc_step;

  // one bit of the byte per cycle, MSB first
  always_comb begin
    crc_step = {crc_reg[14:0], 1'b0} ^ ((crc_reg[15] ^ shift[7]) ? CRC_POLY : 16'h0000);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_reg <= 1'b0;
      cnt      <= '0;
    end else if (ctrl.start) begin
      busy_reg <= 1'b1;
      cnt      <= '0;
    end else if (busy_reg) begin
      cnt <= cnt + 3'd1;
      if (cnt == CntLast) begin
        busy_reg <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      crc_reg <= '0;
    end else if (ctrl.start) begin
      shift <= data_in;
    end else if (busy_reg) begin
      crc_reg <= crc_step;
      shift   <= {shift[6:0], 1'b0};
    end
  end

  assign crc  = crc_reg;
  assign busy = busy_reg;
  assign done = busy_reg && (cnt == CntLast);

endmodule

FILE: hdl/fpr_frame_mem.sv
module fpr_frame_mem #(
  parameter int DEPTH = fpr_pkg::FRAME_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);
  import fpr_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/framed_packet_receiver_crc16.sv
// Header and length bytes, and the two CRC bytes, are not stepped through the CRC unit.
// A body byte covered by the CRC is accepted, then stepped through the bit-serial CRC unit.
// A passing frame is emitted once its last byte is in: each result byte is read from the
// frame store, then held in the output register until taken; L+1 results, ready low meanwhile.
// Reset clears parse and sequencer state and loads the register defaults;
// the frame store is not cleared.
module framed_packet_receiver_crc16 #(
  parameter int FRAME_DEPTH = fpr_pkg::FRAME_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic [3:0] byte_position,
  output logic       frame_last
);
  import fpr_pkg::*;

  localparam int         AW     = $clog2(FRAME_DEPTH);
  localparam logic [8:0] MaxLen = 9'(FRAME_DEPTH - 1);

  logic [7:0] start_first;
  logic [7:0] start_second;
  logic       crc_en;

  phase_t        phase, phase_next;
  seq_t          seq, seq_next;
  logic [AW-1:0] fill_pos, fill_pos_next;
  logic [AW-1:0] len, len_next;
  logic [AW-1:0] emit_k;
  logic [7:0]    prev_byte;

  logic          in_xfer, out_xfer;
  logic          frame_pass;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  crc_ctrl_t     crc_ctrl;
  logic [15:0]   crc;
  logic          crc_busy, crc_done;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_first  <= 8'd0;
      start_second <= 8'd0;
      crc_en       <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_START_FIRST:  start_first  <= cfg_data;
        CFG_START_SECOND: start_second <= cfg_data;
        CFG_CRC_ENABLE:   crc_en       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Byte parser
  always_comb begin
    phase_next    = phase;
    fill_pos_next = fill_pos;
    len_next      = len;
    mem_we        = 1'b0;
    mem_waddr     = fill_pos;
    crc_ctrl      = '0;
    frame_pass    = 1'b0;
    if (in_xfer) begin
      case (phase)
        PH_HUNT0: begin
          if (rx_byte == start_first) begin
            phase_next = PH_HUNT1;
          end
        end
        PH_HUNT1: begin
          phase_next = (rx_byte == start_second) ? PH_LEN : PH_HUNT0;
        end
        PH_LEN: begin
          if (rx_byte == 8'd0 || {1'b0, rx_byte} > MaxLen || (crc_en && rx_byte < 8'd2)) begin
            phase_next    = PH_HUNT0;
            fill_pos_next = '0;
          end else begin
            mem_we         = 1'b1;
            mem_waddr      = '0;
            len_next       = rx_byte[AW-1:0];
            fill_pos_next  = AW'(1);
            phase_next     = PH_BODY;
            crc_ctrl.clear = 1'b1;
          end
        end
        PH_BODY: begin
          mem_we = 1'b1;
          if (fill_pos != len) begin
            fill_pos_next = fill_pos + AW'(1);
            // trailing two bytes are the CRC itself
            crc_ctrl.start = ({1'b0, fill_pos} + (AW+1)'(2)) <= {1'b0, len};
          end else begin
            phase_next    = PH_HUNT0;
            fill_pos_next = '0;
            frame_pass    = !crc_en || (len > AW'(1) && {prev_byte, rx_byte} == crc);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT0;
      fill_pos <= '0;
    end else begin
      phase    <= phase_next;
      fill_pos <= fill_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    len <= len_next;
    if (in_xfer && phase == PH_BODY) begin
      prev_byte <= rx_byte;
    end
  end

  // Sequencer next state
  always_comb begin
    seq_next = seq;
    case (seq)
      SEQ_IDLE: begin
        if (crc_ctrl.start) begin
          seq_next = SEQ_CRC;
        end else if (frame_pass) begin
          seq_next = SEQ_READ;
        end
      end
      SEQ_CRC: begin
        if (crc_done) begin
          seq_next = SEQ_IDLE;
        end
      end
      SEQ_READ: seq_next = SEQ_OUT;
      SEQ_OUT: begin
        if (out_ready) begin
          seq_next = frame_last ? SEQ_IDLE : SEQ_READ;
        end
      end
      default: seq_next = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = (seq == SEQ_IDLE);
    mem_re    = (seq == SEQ_READ);
    out_valid = (seq == SEQ_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SEQ_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_k <= '0;
    end else if (frame_pass) begin
      emit_k <= '0;
    end else if (out_xfer && !frame_last) begin
      emit_k <= emit_k + AW'(1);
    end
  end

  assign byte_position = 4'(emit_k);
  assign frame_last    = (emit_k == len);

  fpr_crc_unit u_crc (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (crc_ctrl),
    .data_in (rx_byte),
    .crc     (crc),
    .busy    (crc_busy),
    .done    (crc_done)
  );

  fpr_frame_mem #(
    .DEPTH (FRAME_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (rx_byte),
    .rd_en   (mem_re),
    .rd_addr (emit_k),
    .rd_data (frame_byte)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted during frame emission");

  a_crc_busy_in_wait: assert property (@(posedge clk) disable iff (rst)
    (seq == SEQ_CRC) |-> crc_busy)
    else $error("sequencer waits on idle CRC unit");

  a_crc_start_idle: assert property (@(posedge clk) disable iff (rst)
    crc_ctrl.start |-> !crc_busy)
    else $error("CRC unit restarted while busy");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (emit_k <= len))
    else $error("emission index past frame length");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && frame_last) |=> in_ready)
    else $error("no return to idle after last transfer");

endmodule
